// ===== src/lvt_pkg.sv =====
// Package for the LRU victim tracker: sizes, command codes and the
// broadcast struct shared by the cells and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lvt_pkg;

  localparam int ENTRIES  = 16;
  localparam int KEY_BITS = 16;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd2;

  typedef struct packed {
    logic                fire;
    logic [CMD_W-1:0]    cmd;
    logic [KEY_BITS-1:0] key;
    logic                any_hit;
  } lvt_bcast_t;

endpackage

`default_nettype wire

// ===== src/lvt_if.sv =====
// Valid/ready channel interfaces for the tracker's request and result sides.
// Depends on lvt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lvt_req_if;
  logic                         valid;
  logic                         ready;
  logic [lvt_pkg::CMD_W-1:0]    command;
  logic [lvt_pkg::KEY_BITS-1:0] key;

  modport source (output valid, output command, output key, input ready);
  modport sink   (input valid, input command, input key, output ready);
endinterface

interface lvt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [lvt_pkg::KEY_BITS-1:0] victim_key;
  logic [lvt_pkg::CNT_W-1:0]    count;

  modport source (output valid, output ok, output victim_key, output count, input ready);
  modport sink   (input valid, input ok, input victim_key, input count, output ready);
endinterface

`default_nettype wire

// ===== src/lru_victim_tracker_core.sv =====
// LRU victim tracker top level: a row of recency cells, the key count and
// the result register. Uses lvt_pkg, lvt_if and lvt_cell.
//
// Usage:
//   in_ch carries one request per transaction: command (insert/touch,
//   take victim, erase) and key. out_ch returns exactly one result per
//   request: ok, victim_key and the count held after the request.
//   Keys sit in cells 0 .. count-1, least recent in cell 0. All cells
//   compare the request key at once; one shift of the row per request
//   does the move, append or removal.
//   The result is registered and appears in the cycle after the request
//   transaction. The tracker accepts one request per cycle while out_ch
//   does not stall; compare and shift work on the whole cell row at once.
//   When out_ch stalls, the result register holds and in_ch.ready drops
//   until the result is taken; a new request is accepted in the same
//   cycle the held result leaves.
//   Reset (rst_n low, synchronous) empties the tracker and drops any
//   pending result; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module lru_victim_tracker_core (
  input  wire        clk,
  input  wire        rst_n,
  lvt_req_if.sink    in_ch,
  lvt_rsp_if.source  out_ch
);

  localparam int N = lvt_pkg::ENTRIES;

  lvt_pkg::lvt_bcast_t         bc;
  logic [N-1:0]                valid_vec;
  logic [N-1:0]                hit_vec;
  logic [lvt_pkg::KEY_BITS-1:0] cell_key [N];
  logic                        fire;
  logic                        full;
  logic                        empty;
  logic                        any_hit;

  logic [lvt_pkg::CNT_W-1:0]    held_count_r, held_count_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_ok_r, out_ok_nxt;
  logic [lvt_pkg::KEY_BITS-1:0] out_victim_r, out_victim_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;
  assign full        = valid_vec[N-1];
  assign empty       = !valid_vec[0];
  assign any_hit     = hit_vec[N-1];

  assign bc.fire    = fire;
  assign bc.cmd     = in_ch.command;
  assign bc.key     = in_ch.key;
  assign bc.any_hit = any_hit;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic                         prev_v;
      logic                         next_v;
      logic [lvt_pkg::KEY_BITS-1:0] next_k;
      logic                         h_in;
      if (g == 0) begin : g_first
        assign prev_v = 1'b1;
        assign h_in   = 1'b0;
      end else begin : g_mid
        assign prev_v = valid_vec[g-1];
        assign h_in   = hit_vec[g-1];
      end
      if (g == N - 1) begin : g_last
        assign next_v = 1'b0;
        assign next_k = '0;
      end else begin : g_up
        assign next_v = valid_vec[g+1];
        assign next_k = cell_key[g+1];
      end
      lvt_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .bc         (bc),
        .prev_valid (prev_v),
        .next_valid (next_v),
        .next_key   (next_k),
        .hit_in     (h_in),
        .hit_out    (hit_vec[g]),
        .valid_o    (valid_vec[g]),
        .key_o      (cell_key[g])
      );
    end
  endgenerate

  always_comb begin
    held_count_nxt = held_count_r;
    out_valid_nxt  = out_valid_r;
    out_ok_nxt     = out_ok_r;
    out_victim_nxt = out_victim_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt  = 1'b1;
      out_ok_nxt     = 1'b0;
      out_victim_nxt = '0;
      case (in_ch.command)
        lvt_pkg::CMD_INSERT: begin
          if (any_hit) begin
            out_ok_nxt = 1'b1;
          end else if (!full) begin
            out_ok_nxt     = 1'b1;
            held_count_nxt = held_count_r + 1'b1;
          end
        end
        lvt_pkg::CMD_VICTIM: begin
          if (!empty) begin
            out_ok_nxt     = 1'b1;
            out_victim_nxt = cell_key[0];
            held_count_nxt = held_count_r - 1'b1;
          end
        end
        lvt_pkg::CMD_ERASE: begin
          if (any_hit) begin
            out_ok_nxt     = 1'b1;
            held_count_nxt = held_count_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      held_count_r <= held_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r     <= out_ok_nxt;
    out_victim_r <= out_victim_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.victim_key = out_victim_r;
  assign out_ch.count      = held_count_r;

  a_count_matches_cells: assert property (
    @(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(held_count_r))
    else $error("held count differs from number of valid cells");

  a_cells_contiguous: assert property (
    @(posedge clk) disable iff (!rst_n)
    ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("valid cells are not packed from cell zero");

  a_empty_victim_fails: assert property (
    @(posedge clk) disable iff (!rst_n)
    (fire && in_ch.command == lvt_pkg::CMD_VICTIM && empty)
      |=> (!out_ok_r && out_victim_r == '0))
    else $error("victim request on empty tracker reported success");

  a_hold_when_stalled: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !fire)
    else $error("request accepted while result is stalled");

endmodule

`default_nettype wire

// ===== src/lvt_cell.sv =====
// One recency cell: holds a key and its valid bit, matches the broadcast key,
// and shifts from its upper neighbor or loads the broadcast key. Uses lvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lvt_cell (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire lvt_pkg::lvt_bcast_t     bc,
  input  wire                          prev_valid,
  input  wire                          next_valid,
  input  wire [lvt_pkg::KEY_BITS-1:0]  next_key,
  input  wire                          hit_in,
  output logic                         hit_out,
  output logic                         valid_o,
  output logic [lvt_pkg::KEY_BITS-1:0] key_o
);

  logic                         valid_r, valid_nxt;
  logic [lvt_pkg::KEY_BITS-1:0] key_r, key_nxt;
  logic                         match;

  assign match   = valid_r && (key_r == bc.key);
  assign hit_out = hit_in | match;
  assign valid_o = valid_r;
  assign key_o   = key_r;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (bc.fire) begin
      case (bc.cmd)
        lvt_pkg::CMD_INSERT: begin
          if (bc.any_hit) begin
            if (hit_out && valid_r) begin
              key_nxt = next_valid ? next_key : bc.key;
            end
          end else if (!valid_r && prev_valid) begin
            key_nxt   = bc.key;
            valid_nxt = 1'b1;
          end
        end
        lvt_pkg::CMD_VICTIM: begin
          key_nxt   = next_key;
          valid_nxt = next_valid;
        end
        lvt_pkg::CMD_ERASE: begin
          if (hit_out) begin
            key_nxt   = next_key;
            valid_nxt = next_valid;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

// ===== verif/lru_victim_tracker_core_tb.sv =====
// Testbench for lru_victim_tracker_core: directed and random request traffic,
// checked transaction by transaction against an in-bench LRU order predictor.
// Depends on lvt_pkg, lvt_if and the tracker RTL.
`timescale 1ns / 1ps

module lru_victim_tracker_core_tb;

  localparam logic [lvt_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int HOLD_CYCLES   = 120;
  localparam int STALL_LIMIT   = 2000;
  localparam int POOL_SIZE     = 20;

  typedef struct {
    logic                         ok;
    logic [lvt_pkg::KEY_BITS-1:0] victim_key;
    logic [lvt_pkg::CNT_W-1:0]    count;
  } tracker_result_t;

  logic clk;
  logic rst_n;

  lvt_req_if req_ch();
  lvt_rsp_if rsp_ch();

  lru_victim_tracker_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  // Predictor state: least recent key at the front.
  logic [lvt_pkg::KEY_BITS-1:0] lru_order[$];
  tracker_result_t              pending_results[$];
  logic [lvt_pkg::KEY_BITS-1:0] key_pool[POOL_SIZE];

  int errors;
  int sent_count;
  int checked_count;
  int victims_taken;
  int full_refusals;
  int burst_left;
  int holds_asked;
  int holds_granted;
  int idle_cycles;
  int stall_mode;
  int mode_left;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic void predict_request(input logic [lvt_pkg::CMD_W-1:0] cmd,
                                          input logic [lvt_pkg::KEY_BITS-1:0] key);
    tracker_result_t res;
    int pos;
    res.ok = 1'b0;
    res.victim_key = '0;
    pos = -1;
    foreach (lru_order[i]) if (lru_order[i] == key) pos = i;
    case (cmd)
      lvt_pkg::CMD_INSERT: begin
        if (pos >= 0) begin
          lru_order.delete(pos);
          lru_order.push_back(key);
          res.ok = 1'b1;
        end else if (lru_order.size() < lvt_pkg::ENTRIES) begin
          lru_order.push_back(key);
          res.ok = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      lvt_pkg::CMD_VICTIM: begin
        if (lru_order.size() > 0) begin
          res.victim_key = lru_order.pop_front();
          res.ok = 1'b1;
          victims_taken++;
        end
      end
      lvt_pkg::CMD_ERASE: begin
        if (pos >= 0) begin
          lru_order.delete(pos);
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = lvt_pkg::CNT_W'(lru_order.size());
    pending_results.push_back(res);
  endfunction

  task automatic send_request(input logic [lvt_pkg::CMD_W-1:0] cmd,
                              input logic [lvt_pkg::KEY_BITS-1:0] key);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.key     <= key;
    do @(posedge clk); while (!req_ch.ready);
    predict_request(cmd, key);
    sent_count++;
  endtask

  function automatic logic [lvt_pkg::KEY_BITS-1:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [lvt_pkg::CMD_W-1:0] pick_command(input int insert_pct,
                                                             input int victim_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) return lvt_pkg::CMD_INSERT;
    if (roll < insert_pct + victim_pct) return lvt_pkg::CMD_VICTIM;
    if (roll < 97) return lvt_pkg::CMD_ERASE;
    return CMD_NOP;
  endfunction

  task automatic test_empty_corners();
    send_request(lvt_pkg::CMD_VICTIM, 16'hFFFF);
    send_request(lvt_pkg::CMD_ERASE, 16'h0000);
    send_request(CMD_NOP, 16'hFFFF);
  endtask

  task automatic test_fill_and_full();
    send_request(lvt_pkg::CMD_INSERT, 16'h0000);
    send_request(lvt_pkg::CMD_INSERT, 16'hFFFF);
    send_request(lvt_pkg::CMD_INSERT, 16'h0000);
    for (int i = 1; i <= lvt_pkg::ENTRIES - 2; i++) begin
      send_request(lvt_pkg::CMD_INSERT, 16'(16'h0101 * i));
    end
    send_request(lvt_pkg::CMD_INSERT, 16'h8001);
    send_request(lvt_pkg::CMD_INSERT, 16'hFFFF);
    send_request(CMD_NOP, 16'h5555);
  endtask

  task automatic test_removals();
    send_request(lvt_pkg::CMD_ERASE, 16'h0000);
    send_request(lvt_pkg::CMD_ERASE, 16'h8001);
    send_request(lvt_pkg::CMD_VICTIM, 16'h0000);
  endtask

  task automatic test_random_traffic(input int n_items);
    int insert_pct;
    int victim_pct;
    for (int i = 0; i < n_items; i++) begin
      // drift between fill-heavy, drain-heavy and balanced traffic
      case ((i / 60) % 3)
        0: begin insert_pct = 75; victim_pct = 10; end
        1: begin insert_pct = 25; victim_pct = 40; end
        default: begin insert_pct = 48; victim_pct = 24; end
      endcase
      send_request(pick_command(insert_pct, victim_pct), pick_key());
    end
  endtask

  task automatic test_backpressure();
    holds_asked++;
    for (int i = 0; i < 40; i++) send_request(pick_command(60, 20), pick_key());
  endtask

  // Result side stall pattern, with long hold-offs on request.
  initial begin
    rsp_ch.ready = 1'b0;
    stall_mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (holds_granted != holds_asked) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        holds_granted++;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (stall_mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
          2: rsp_ch.ready <= mode_left[0];
          default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_result
    tracker_result_t exp_res;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result ok=%0b victim_key=%h count=%0d",
                 $time, rsp_ch.ok, rsp_ch.victim_key, rsp_ch.count);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        checked_count++;
        if (rsp_ch.ok !== exp_res.ok) begin
          $display("%0t: ok mismatch, expected %0b, got %0b", $time, exp_res.ok, rsp_ch.ok);
          errors++;
        end
        if (rsp_ch.victim_key !== exp_res.victim_key) begin
          $display("%0t: victim_key mismatch, expected %h, got %h",
                   $time, exp_res.victim_key, rsp_ch.victim_key);
          errors++;
        end
        if (rsp_ch.count !== exp_res.count) begin
          $display("%0t: count mismatch, expected %0d, got %0d",
                   $time, exp_res.count, rsp_ch.count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    errors = 0;
    sent_count = 0;
    checked_count = 0;
    victims_taken = 0;
    full_refusals = 0;
    burst_left = 0;
    holds_asked = 0;
    holds_granted = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.command = lvt_pkg::CMD_INSERT;
    req_ch.key = '0;
    foreach (key_pool[i]) key_pool[i] = 16'($urandom_range(0, 16'hFFFF));
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_corners();
    test_fill_and_full();
    test_removals();
    test_random_traffic(450);
    test_backpressure();
    test_random_traffic(450);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("tb: %0d requests sent, %0d results checked", sent_count, checked_count);
    $display("tb: %0d victims taken, %0d inserts refused on a full tracker",
             victims_taken, full_refusals);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
